/* rtl/swm_pkg.sv */
package swm_pkg;

  localparam int unsigned CFG_WIDTH  = 7;
  localparam int unsigned DATA_WIDTH = 32;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_UP,
    ST_WR_UP,
    ST_SCAN_DN,
    ST_WR_DN,
    ST_EMIT
  } swm_state_e;

endpackage

/* rtl/swm_ring.sv */
module swm_ring #(
  parameter int unsigned WINDOW_MAX = 64,
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned IW         = $clog2(WINDOW_MAX + 1),
  parameter int unsigned AW         = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  restart_i,
  input  logic                  push_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [IW-1:0]         k_i,
  output logic                  emit_o,
  output logic [VALUE_BITS-1:0] oldest_o
);

  localparam int unsigned SW = IW + 1;

  logic [VALUE_BITS-1:0] mem [WINDOW_MAX];
  logic [AW-1:0]         ptr_q, ptr_d;
  logic [IW-1:0]         fill_q, fill_d;
  logic [SW-1:0]         old_sum;
  logic [AW-1:0]         old_addr;
  logic [VALUE_BITS-1:0] rd_q;

  always_comb begin
    old_sum = SW'(ptr_q) + SW'(1) + SW'(WINDOW_MAX) - SW'(k_i);
    if (old_sum >= SW'(WINDOW_MAX)) begin
      old_sum = old_sum - SW'(WINDOW_MAX);
    end
    old_addr = old_sum[AW-1:0];
  end

  assign emit_o = (IW'(fill_q + IW'(1)) == k_i);

  always_comb begin
    ptr_d  = ptr_q;
    fill_d = fill_q;
    if (restart_i) begin
      ptr_d  = '0;
      fill_d = '0;
    end else if (push_i) begin
      ptr_d = (ptr_q == AW'(WINDOW_MAX - 1)) ? '0 : AW'(ptr_q + AW'(1));
      if (!emit_o) begin
        fill_d = IW'(fill_q + IW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      fill_q <= '0;
    end else begin
      ptr_q  <= ptr_d;
      fill_q <= fill_d;
    end
  end

  // window of one: the oldest value is the one being written
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[ptr_q] <= value_i;
      rd_q       <= (old_addr == ptr_q) ? value_i : mem[old_addr];
    end
  end

  assign oldest_o = rd_q;

endmodule

/* rtl/swm_table.sv */
module swm_table #(
  parameter int unsigned WINDOW_MAX = 64,
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned IW         = $clog2(WINDOW_MAX + 1),
  parameter int unsigned AW         = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [VALUE_BITS-1:0] wval_i,
  input  logic [IW-1:0]         wcnt_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [VALUE_BITS-1:0] rval_o,
  output logic [IW-1:0]         rcnt_o
);

  logic [VALUE_BITS+IW-1:0] mem [WINDOW_MAX];
  logic [VALUE_BITS+IW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wval_i, wcnt_i};
    end
    if (re_i) begin
      rd_q <= mem[raddr_i];
    end
  end

  assign rval_o = rd_q[VALUE_BITS+IW-1:IW];
  assign rcnt_o = rd_q[IW-1:0];

endmodule

/* rtl/sliding_window_mode.sv */
// Sliding window mode.
// Input beats on s_axis carry one sample each (tdata = sample_value). Once the
// window holds window_size samples, every input beat yields one output beat on
// m_axis with the window's mode (most frequent value, smallest on a tie), and
// the oldest sample leaves the window. While the window fills, no output.
// cfg: a beat on cfg_valid_i/cfg_ready_o writes window_size (0 acts as 1,
// values above WINDOW_MAX saturate) and restarts the stream from empty.
// A sample costs one pass over the count table memory while the window
// fills and two once it is full, one read per cycle. One sample is in work
// at a time. After reset and after each cfg beat, a clearing pass zeroes the
// counts; s_axis_tready stays low meanwhile.
// The output register holds a result while m_axis_tready is low; the next
// sample is accepted and processed meanwhile, and its result waits until the
// register is free.
module sliding_window_mode #(
  parameter int unsigned WINDOW_MAX = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [swm_pkg::DATA_WIDTH-1:0]  s_axis_tdata,   // [31:0] sample_value
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [swm_pkg::DATA_WIDTH-1:0]  m_axis_tdata,   // [31:0] mode_value
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [swm_pkg::CFG_WIDTH-1:0]   cfg_data_i
);

  localparam int unsigned IW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  swm_pkg::swm_state_e   state_q, state_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [IW-1:0]         k_q, k_d;
  logic                  out_vld_q;
  logic [VALUE_BITS-1:0] out_q;

  logic                  s_acc, cfg_acc, load_out;
  logic [VALUE_BITS-1:0] sample;
  logic                  ring_emit;
  logic [VALUE_BITS-1:0] oldest;

  logic                  tbl_we, tbl_re;
  logic [AW-1:0]         tbl_waddr;
  logic [VALUE_BITS-1:0] tbl_wval, tbl_rval;
  logic [IW-1:0]         tbl_wcnt, tbl_rcnt;

  logic [VALUE_BITS-1:0] val_q;
  logic                  emit_q;
  logic                  hit_q, free_q;
  logic [AW-1:0]         hit_slot_q, free_slot_q, dn_slot_q;
  logic [IW-1:0]         hit_cnt_q, dn_cnt_q, best_cnt_q;
  logic [VALUE_BITS-1:0] best_val_q;
  logic [IW-1:0]         prev_idx;
  logic [AW-1:0]         slot;
  logic                  rd_ok;

  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == swm_pkg::ST_IDLE);
  assign sample        = VALUE_BITS'(s_axis_tdata);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = swm_pkg::DATA_WIDTH'(out_q);

  assign prev_idx = IW'(idx_q - IW'(1));
  assign slot     = prev_idx[AW-1:0];
  assign rd_ok    = (idx_q != '0);

  always_comb begin
    if (cfg_data_i == '0) begin
      k_d = IW'(1);
    end else if (32'(cfg_data_i) > 32'(WINDOW_MAX)) begin
      k_d = IW'(WINDOW_MAX);
    end else begin
      k_d = IW'(cfg_data_i);
    end
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    tbl_we    = 1'b0;
    tbl_waddr = idx_q[AW-1:0];
    tbl_wval  = '0;
    tbl_wcnt  = '0;
    tbl_re    = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      swm_pkg::ST_CLEAR: begin
        tbl_we = 1'b1;
        if (idx_q == IW'(WINDOW_MAX - 1)) begin
          state_d = swm_pkg::ST_IDLE;
          idx_d   = '0;
        end else begin
          idx_d = IW'(idx_q + IW'(1));
        end
      end
      swm_pkg::ST_IDLE: begin
        if (s_acc) begin
          state_d = swm_pkg::ST_SCAN_UP;
          idx_d   = '0;
        end
      end
      swm_pkg::ST_SCAN_UP, swm_pkg::ST_SCAN_DN: begin
        tbl_re = (idx_q != IW'(WINDOW_MAX));
        if (idx_q == IW'(WINDOW_MAX)) begin
          state_d = (state_q == swm_pkg::ST_SCAN_UP) ? swm_pkg::ST_WR_UP
                                                      : swm_pkg::ST_WR_DN;
          idx_d   = '0;
        end else begin
          idx_d = IW'(idx_q + IW'(1));
        end
      end
      swm_pkg::ST_WR_UP: begin
        tbl_we    = 1'b1;
        tbl_waddr = hit_q ? hit_slot_q : free_slot_q;
        tbl_wval  = val_q;
        tbl_wcnt  = hit_q ? IW'(hit_cnt_q + IW'(1)) : IW'(1);
        state_d   = emit_q ? swm_pkg::ST_SCAN_DN : swm_pkg::ST_IDLE;
      end
      swm_pkg::ST_WR_DN: begin
        tbl_we    = 1'b1;
        tbl_waddr = dn_slot_q;
        tbl_wval  = oldest;
        tbl_wcnt  = IW'(dn_cnt_q - IW'(1));
        state_d   = swm_pkg::ST_EMIT;
      end
      swm_pkg::ST_EMIT: begin
        if (!out_vld_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = swm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swm_pkg::ST_CLEAR;
        idx_d   = '0;
      end
    endcase
    if (cfg_acc) begin
      state_d = swm_pkg::ST_CLEAR;
      idx_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= swm_pkg::ST_CLEAR;
      idx_q     <= '0;
      k_q       <= IW'(1);
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (cfg_acc) begin
        k_q <= k_d;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= best_val_q;
    end
    if (s_acc) begin
      val_q      <= sample;
      emit_q     <= ring_emit;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      best_cnt_q <= '0;
      best_val_q <= '0;
    end
    if (state_q == swm_pkg::ST_SCAN_UP && rd_ok) begin
      if (tbl_rcnt != '0 && tbl_rval == val_q) begin
        hit_q      <= 1'b1;
        hit_slot_q <= slot;
        hit_cnt_q  <= tbl_rcnt;
      end else if (tbl_rcnt == '0 && !free_q) begin
        free_q      <= 1'b1;
        free_slot_q <= slot;
      end
    end
    if (state_q == swm_pkg::ST_SCAN_DN && rd_ok && tbl_rcnt != '0) begin
      if (tbl_rcnt > best_cnt_q || (tbl_rcnt == best_cnt_q && tbl_rval < best_val_q)) begin
        best_cnt_q <= tbl_rcnt;
        best_val_q <= tbl_rval;
      end
      if (tbl_rval == oldest) begin
        dn_slot_q <= slot;
        dn_cnt_q  <= tbl_rcnt;
      end
    end
  end

  swm_ring #(
    .WINDOW_MAX (WINDOW_MAX),
    .VALUE_BITS (VALUE_BITS),
    .IW         (IW),
    .AW         (AW)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_acc),
    .push_i    (s_acc),
    .value_i   (sample),
    .k_i       (k_q),
    .emit_o    (ring_emit),
    .oldest_o  (oldest)
  );

  swm_table #(
    .WINDOW_MAX (WINDOW_MAX),
    .VALUE_BITS (VALUE_BITS),
    .IW         (IW),
    .AW         (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wval_i  (tbl_wval),
    .wcnt_i  (tbl_wcnt),
    .re_i    (tbl_re),
    .raddr_i (idx_q[AW-1:0]),
    .rval_o  (tbl_rval),
    .rcnt_o  (tbl_rcnt)
  );

endmodule

/* rtl/swm_checker.sv */
module swm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [swm_pkg::DATA_WIDTH-1:0]  m_axis_tdata,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped or changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a sample is in work");

  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !s_axis_tready)
    else $error("input open before clearing pass");

  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result shown before table passes");

endmodule

bind sliding_window_mode swm_checker u_swm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o)
);

/* dv/tb_sliding_window_mode.sv */
module tb_sliding_window_mode;

  localparam int unsigned DATA_WIDTH = swm_pkg::DATA_WIDTH;
  localparam int unsigned CFG_WIDTH  = swm_pkg::CFG_WIDTH;

  localparam int unsigned WIN_MAX = 64;
  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam int unsigned DRAIN_CYCLES = 4 * WIN_MAX + 20;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_SAMPLE,
    ROW_SAMPLE_EXP
  } row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [DATA_WIDTH-1:0] data;
    logic [DATA_WIDTH-1:0] want;
  } stim_row_t;

  localparam int unsigned NUM_ROWS = 24;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_SAMPLE_EXP, 32'h0000_0000, 32'h0000_0000},
    '{ROW_SAMPLE_EXP, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{ROW_SAMPLE_EXP, 32'h8000_0001, 32'h8000_0001},
    '{ROW_CFG,        32'd0,         32'd0},
    '{ROW_SAMPLE_EXP, 32'h1234_5678, 32'h1234_5678},
    '{ROW_CFG,        32'd3,         32'd0},
    '{ROW_SAMPLE,     32'd5,         32'd0},
    '{ROW_SAMPLE,     32'd7,         32'd0},
    '{ROW_SAMPLE_EXP, 32'd7,         32'd7},
    '{ROW_SAMPLE_EXP, 32'd5,         32'd7},
    '{ROW_SAMPLE_EXP, 32'd5,         32'd5},
    '{ROW_SAMPLE_EXP, 32'd9,         32'd5},
    '{ROW_SAMPLE_EXP, 32'd1,         32'd1},
    '{ROW_CFG,        32'd2,         32'd0},
    '{ROW_SAMPLE,     32'hFFFF_FFFF, 32'd0},
    '{ROW_SAMPLE_EXP, 32'h0000_0000, 32'h0000_0000},
    '{ROW_SAMPLE_EXP, 32'hFFFF_FFFF, 32'h0000_0000},
    '{ROW_CFG,        32'd127,       32'd0},
    '{ROW_SAMPLE,     32'hA5A5_A5A5, 32'd0},
    '{ROW_SAMPLE,     32'h5A5A_5A5A, 32'd0},
    '{ROW_CFG,        32'd1,         32'd0},
    '{ROW_SAMPLE_EXP, 32'hDEAD_BEEF, 32'hDEAD_BEEF},
    '{ROW_CFG,        32'd64,        32'd0},
    '{ROW_SAMPLE,     32'd3,         32'd0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [DATA_WIDTH-1:0] s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [DATA_WIDTH-1:0] m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_WIDTH-1:0]  cfg_data_i;

  logic [DATA_WIDTH-1:0] window_q [$];
  logic [DATA_WIDTH-1:0] mode_q [$];
  int unsigned           win_len;
  int unsigned           mismatches;
  bit                    idle_on;

  sliding_window_mode #(
    .WINDOW_MAX(WIN_MAX),
    .VALUE_BITS(DATA_WIDTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [DATA_WIDTH-1:0] got,
                                 input logic [DATA_WIDTH-1:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Add a sample to the window; on a full window return its mode and drop the oldest.
  function automatic bit window_push(input logic [DATA_WIDTH-1:0] v,
                                     output logic [DATA_WIDTH-1:0] mode);
    int unsigned best_cnt;
    int unsigned cnt;
    mode = '0;
    best_cnt = 0;
    window_q = {window_q, v};
    if (window_q.size() < win_len) return 1'b0;
    foreach (window_q[i]) begin
      cnt = 0;
      foreach (window_q[j]) if (window_q[j] == window_q[i]) cnt++;
      if (cnt > best_cnt || (cnt == best_cnt && window_q[i] < mode)) begin
        best_cnt = cnt;
        mode = window_q[i];
      end
    end
    void'(window_q.pop_front());
    return 1'b1;
  endfunction

  task automatic send_sample(input logic [DATA_WIDTH-1:0] v, input bit typed,
                             input logic [DATA_WIDTH-1:0] want);
    int unsigned gap;
    logic [DATA_WIDTH-1:0] mode;
    @(negedge clk_i);
    gap = idle_on ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= v;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (window_push(v, mode)) mode_q = {mode_q, (typed ? want : mode)};
  endtask

  task automatic write_window_size(input logic [CFG_WIDTH-1:0] size);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (mode_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_data_i  <= size;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    win_len = (size == 0) ? 1 : ((size > WIN_MAX) ? WIN_MAX : size);
    window_q.delete();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : result_sink
    int unsigned stall;
    logic [DATA_WIDTH-1:0] want;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      stall = idle_on ? $urandom_range(0, 14) : 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      if (mode_q.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata, '0);
      end else begin
        want = mode_q.pop_front();
        if (m_axis_tdata !== want) report_mismatch("mode_value", m_axis_tdata, want);
      end
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase_len;
    int unsigned pool_len;
    int unsigned pick;
    logic [CFG_WIDTH-1:0]  size;
    logic [DATA_WIDTH-1:0] pool [8];
    logic [DATA_WIDTH-1:0] v;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    mismatches    = 0;
    win_len       = 1;
    idle_on       = 1'b1;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        write_window_size(directed_rows[r].data[CFG_WIDTH-1:0]);
      end else begin
        send_sample(directed_rows[r].data, directed_rows[r].kind == ROW_SAMPLE_EXP,
                    directed_rows[r].want);
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: size = '0;
        1: size = CFG_WIDTH'(1);
        2: size = CFG_WIDTH'(WIN_MAX);
        3: size = '1;
        4: size = CFG_WIDTH'($urandom_range(WIN_MAX + 1, 126));
        default: size = CFG_WIDTH'($urandom_range(2, 12));
      endcase
      write_window_size(size);
      idle_on   = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(20, 120);
      pool_len  = $urandom_range(1, 8);
      foreach (pool[p]) pool[p] = $urandom();
      repeat (phase_len) begin
        pick = $urandom_range(0, 19);
        case (pick)
          0: v = '0;
          1: v = '1;
          2: v = 32'h1 << $urandom_range(0, DATA_WIDTH - 1);
          3, 4: v = $urandom();
          default: v = pool[$urandom_range(0, pool_len - 1)];
        endcase
        send_sample(v, 1'b0, '0);
        sent++;
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (mode_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/swm_pkg.sv
rtl/swm_ring.sv
rtl/swm_table.sv
rtl/sliding_window_mode.sv
rtl/swm_checker.sv
dv/tb_sliding_window_mode.sv
